// ===== rtl/cpd_pkg.sv =====
`timescale 1ns / 1ps

package cpd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 20;
    localparam int REG_W      = DATA_WIDTH - 1;
    localparam int NUM_REGS   = 7;
    localparam int IDX_W      = 3;
    localparam int PROD_W     = 2 * DATA_WIDTH;

    typedef logic signed [DATA_WIDTH-1:0] t_fx;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic [REG_W-1:0]             t_reg;
    typedef logic [IDX_W-1:0]             t_idx;

    localparam t_idx REG_GRAVITY      = 3'd0;
    localparam t_idx REG_CART_FRIC    = 3'd1;
    localparam t_idx REG_MASS_LEN     = 3'd2;
    localparam t_idx REG_TOTAL_MASS   = 3'd3;
    localparam t_idx REG_INV_MASS     = 3'd4;
    localparam t_idx REG_DAMP_ML      = 3'd5;
    localparam t_idx REG_FOUR_THIRDS  = 3'd6;

    localparam t_reg REG_RESET [NUM_REGS] = '{
        31'd10286531, 31'd15309210, 31'd9185526, 31'd22963814,
        31'd47880, 31'd1628, 31'd1677722
    };

    localparam t_fx MAX_FX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_fx MIN_FX = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // angle reduction and CORDIC, Q30 inside
    localparam int Q_CORDIC     = 30;
    localparam int RW           = 33;
    localparam int ZW           = 35;
    localparam int XYW          = 34;
    localparam int RED_STEPS    = 10;
    localparam int CORDIC_STEPS = 30;

    localparam logic [RW-1:0]        TWO_PI_FX   = 33'd6588397;
    localparam logic [RW-1:0]        WRAP_OFFSET = 33'd2147817422;
    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [XYW-1:0] GAIN_Q30   = 34'sd652032874;

    // divider
    localparam int DIV_BITS = DATA_WIDTH + FRAC_BITS;

    typedef struct packed {
        t_fx cart_velocity;
        t_fx pole_angle;
        t_fx pole_rate;
        t_fx force_req;
    } t_req;

    typedef struct packed {
        t_fx  position_rate;
        t_fx  velocity_rate;
        t_fx  angle_rate;
        t_fx  angular_accel;
        logic saturated;
    } t_res;

    typedef struct packed {
        logic ovf;
        t_fx  val;
    } t_sat;

    typedef struct packed {
        t_fx  v;
        t_fx  w;
        t_fx  t1;
        t_fx  mlc;
        logic ovf;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        case (i)
            0:       atan_q30 = 35'sd843314857;
            1:       atan_q30 = 35'sd497837829;
            2:       atan_q30 = 35'sd263043837;
            3:       atan_q30 = 35'sd133525159;
            4:       atan_q30 = 35'sd67021687;
            5:       atan_q30 = 35'sd33543516;
            6:       atan_q30 = 35'sd16775851;
            7:       atan_q30 = 35'sd8388437;
            8:       atan_q30 = 35'sd4194283;
            9:       atan_q30 = 35'sd2097149;
            default: atan_q30 = ZW'(64'sd1 <<< (Q_CORDIC - i));
        endcase
    endfunction

    function automatic t_prod mul_raw(input t_fx a, input t_fx b);
        t_prod pa;
        t_prod pb;
        pa = PROD_W'(a);
        pb = PROD_W'(b);
        mul_raw = pa * pb;
    endfunction

    // round half away from zero, then saturate
    function automatic t_sat mul_round(input t_prod p);
        logic                          neg;
        logic [PROD_W-1:0]             mag;
        logic [PROD_W-1:0]             rnd;
        logic [PROD_W-FRAC_BITS-1:0]   q;
        logic [PROD_W-FRAC_BITS-1:0]   lim;
        t_sat                          r;
        neg = p[PROD_W-1];
        mag = neg ? (~p + PROD_W'(1)) : p;
        rnd = mag + (PROD_W'(1) << (FRAC_BITS - 1));
        q   = rnd[PROD_W-1:FRAC_BITS];
        lim = (PROD_W-FRAC_BITS)'(MAX_FX) + (PROD_W-FRAC_BITS)'(neg);
        if (q > lim) begin
            r.ovf = 1'b1;
            r.val = neg ? MIN_FX : MAX_FX;
        end else begin
            r.ovf = 1'b0;
            r.val = neg ? t_fx'(~q[DATA_WIDTH-1:0] + DATA_WIDTH'(1)) : t_fx'(q[DATA_WIDTH-1:0]);
        end
        mul_round = r;
    endfunction

    function automatic t_sat add_sat(input t_fx a, input t_fx b, input logic sub);
        logic signed [DATA_WIDTH:0] s;
        t_sat                       r;
        s = sub ? ({a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b})
                : ({a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b});
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            r.ovf = 1'b1;
            r.val = s[DATA_WIDTH] ? MIN_FX : MAX_FX;
        end else begin
            r.ovf = 1'b0;
            r.val = s[DATA_WIDTH-1:0];
        end
        add_sat = r;
    endfunction

endpackage

// ===== rtl/cpd_cordic.sv =====
`timescale 1ns / 1ps

module cpd_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cpd_pkg::t_req   i_req,
    output logic            o_valid,
    output cpd_pkg::t_req   o_req,
    output cpd_pkg::t_fx    o_sin,
    output cpd_pkg::t_fx    o_cos
);

    localparam int RED = cpd_pkg::RED_STEPS;
    localparam int CS  = cpd_pkg::CORDIC_STEPS;
    localparam int XW  = cpd_pkg::XYW;
    localparam int ZWD = cpd_pkg::ZW;
    localparam int SH  = cpd_pkg::Q_CORDIC - cpd_pkg::FRAC_BITS;

    logic [RED:0]                  r_red_vld;
    logic [cpd_pkg::RW-1:0]        r_red_x   [0:RED];
    cpd_pkg::t_req                 r_red_req [0:RED];

    logic                          r_wr_vld;
    logic signed [ZWD-1:0]         r_wr_z;
    cpd_pkg::t_req                 r_wr_req;

    logic [CS:0]                   r_c_vld;
    logic signed [XW-1:0]          r_c_x    [0:CS];
    logic signed [XW-1:0]          r_c_y    [0:CS];
    logic signed [ZWD-1:0]         r_c_z    [0:CS];
    logic                          r_c_flip [0:CS];
    cpd_pkg::t_req                 r_c_req  [0:CS];

    logic                          r_out_vld;
    cpd_pkg::t_req                 r_out_req;
    cpd_pkg::t_fx                  r_out_sin;
    cpd_pkg::t_fx                  r_out_cos;

    logic signed [ZWD-1:0]         n_wr_z0;
    logic signed [ZWD-1:0]         n_wr_z;
    logic signed [ZWD-1:0]         n_fl_z;
    logic                          n_fl_flip;
    logic signed [XW-1:0]          n_out_x;
    logic signed [XW-1:0]          n_out_y;

    function automatic cpd_pkg::t_fx q30_round(input logic signed [XW-1:0] v);
        logic [XW-1:0] mag;
        logic [XW-1:0] rnd;
        mag = v[XW-1] ? (~v + XW'(1)) : v;
        rnd = (mag + (XW'(1) << (SH - 1))) >> SH;
        q30_round = v[XW-1] ? cpd_pkg::t_fx'(~rnd[cpd_pkg::DATA_WIDTH-1:0] + 32'd1)
                            : cpd_pkg::t_fx'(rnd[cpd_pkg::DATA_WIDTH-1:0]);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_vld <= '0;
            r_wr_vld  <= 1'b0;
            r_c_vld   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_red_vld <= {r_red_vld[RED-1:0], i_valid};
            r_wr_vld  <= r_red_vld[RED];
            r_c_vld   <= {r_c_vld[CS-1:0], r_wr_vld};
            r_out_vld <= r_c_vld[CS];
        end
    end

    // shift the angle positive, then take out multiples of two pi
    always_ff @(posedge i_clk) begin
        r_red_x[0]   <= {i_req.pole_angle[cpd_pkg::DATA_WIDTH-1], i_req.pole_angle}
                        + cpd_pkg::WRAP_OFFSET;
        r_red_req[0] <= i_req;
    end

    for (genvar k = 0; k < RED; k++) begin : g_red
        localparam logic [cpd_pkg::RW-1:0] SUB = cpd_pkg::TWO_PI_FX << (RED - 1 - k);
        logic [cpd_pkg::RW-1:0] n_x;
        assign n_x = (r_red_x[k] >= SUB) ? (r_red_x[k] - SUB) : r_red_x[k];
        always_ff @(posedge i_clk) begin
            r_red_x[k+1]   <= n_x;
            r_red_req[k+1] <= r_red_req[k];
        end
    end

    always_comb begin
        n_wr_z0 = $signed({2'b00, r_red_x[RED]}) <<< SH;
        n_wr_z  = (n_wr_z0 > cpd_pkg::PI_Q30) ? (n_wr_z0 - cpd_pkg::TWO_PI_Q30) : n_wr_z0;
    end

    always_ff @(posedge i_clk) begin
        r_wr_z   <= n_wr_z;
        r_wr_req <= r_red_req[RED];
    end

    always_comb begin
        n_fl_z    = r_wr_z;
        n_fl_flip = 1'b0;
        if (r_wr_z > cpd_pkg::HALF_PI_Q30) begin
            n_fl_z    = r_wr_z - cpd_pkg::PI_Q30;
            n_fl_flip = 1'b1;
        end else if (r_wr_z < -cpd_pkg::HALF_PI_Q30) begin
            n_fl_z    = r_wr_z + cpd_pkg::PI_Q30;
            n_fl_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_x[0]    <= cpd_pkg::GAIN_Q30;
        r_c_y[0]    <= '0;
        r_c_z[0]    <= n_fl_z;
        r_c_flip[0] <= n_fl_flip;
        r_c_req[0]  <= r_wr_req;
    end

    for (genvar i = 0; i < CS; i++) begin : g_rot
        localparam logic signed [ZWD-1:0] ANG = cpd_pkg::atan_q30(i);
        logic signed [XW-1:0] n_xs;
        logic signed [XW-1:0] n_ys;
        assign n_xs = r_c_x[i] >>> i;
        assign n_ys = r_c_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!r_c_z[i][ZWD-1]) begin
                r_c_x[i+1] <= r_c_x[i] - n_ys;
                r_c_y[i+1] <= r_c_y[i] + n_xs;
                r_c_z[i+1] <= r_c_z[i] - ANG;
            end else begin
                r_c_x[i+1] <= r_c_x[i] + n_ys;
                r_c_y[i+1] <= r_c_y[i] - n_xs;
                r_c_z[i+1] <= r_c_z[i] + ANG;
            end
            r_c_flip[i+1] <= r_c_flip[i];
            r_c_req[i+1]  <= r_c_req[i];
        end
    end

    always_comb begin
        n_out_x = r_c_flip[CS] ? -r_c_x[CS] : r_c_x[CS];
        n_out_y = r_c_flip[CS] ? -r_c_y[CS] : r_c_y[CS];
    end

    always_ff @(posedge i_clk) begin
        r_out_sin <= q30_round(n_out_y);
        r_out_cos <= q30_round(n_out_x);
        r_out_req <= r_c_req[CS];
    end

    assign o_valid = r_out_vld;
    assign o_req   = r_out_req;
    assign o_sin   = r_out_sin;
    assign o_cos   = r_out_cos;

endmodule

// ===== rtl/cpd_divider.sv =====
`timescale 1ns / 1ps

module cpd_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cpd_pkg::t_fx    i_num,
    input  cpd_pkg::t_fx    i_den,
    input  cpd_pkg::t_side  i_side,
    output logic            o_valid,
    output cpd_pkg::t_sat   o_quot,
    output cpd_pkg::t_side  o_side
);

    localparam int DW = cpd_pkg::DATA_WIDTH;
    localparam int NB = cpd_pkg::DIV_BITS;

    typedef struct packed {
        logic [DW-1:0]  ud;
        logic           neg;
        logic           dz;
        logic           npos;
        logic           nneg;
        cpd_pkg::t_side side;
    } t_dctl;

    logic [NB:0]     r_vld;
    logic [NB-1:0]   r_dvd [0:NB];
    logic [DW-1:0]   r_rem [0:NB];
    logic [DW-1:0]   r_q   [0:NB];
    logic            r_big [0:NB];
    t_dctl           r_ctl [0:NB];

    logic            r_out_vld;
    cpd_pkg::t_sat   r_out_quot;
    cpd_pkg::t_side  r_out_side;

    logic [DW-1:0]   n_un;
    logic [DW-1:0]   n_ud;
    logic [DW:0]     n_lim;
    cpd_pkg::t_sat   n_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[NB-1:0], i_valid};
            r_out_vld <= r_vld[NB];
        end
    end

    always_comb begin
        n_un = i_num[DW-1] ? (~i_num + DW'(1)) : i_num;
        n_ud = i_den[DW-1] ? (~i_den + DW'(1)) : i_den;
    end

    always_ff @(posedge i_clk) begin
        r_dvd[0]       <= {n_un, {cpd_pkg::FRAC_BITS{1'b0}}};
        r_rem[0]       <= '0;
        r_q[0]         <= '0;
        r_big[0]       <= 1'b0;
        r_ctl[0].ud    <= n_ud;
        r_ctl[0].neg   <= i_num[DW-1] ^ i_den[DW-1];
        r_ctl[0].dz    <= (i_den == '0);
        r_ctl[0].npos  <= !i_num[DW-1] && (i_num != '0);
        r_ctl[0].nneg  <= i_num[DW-1];
        r_ctl[0].side  <= i_side;
    end

    for (genvar j = 0; j < NB; j++) begin : g_bit
        logic [DW:0] n_rs;
        logic [DW:0] n_diff;
        logic        n_ge;
        assign n_rs   = {r_rem[j], r_dvd[j][NB-1]};
        assign n_ge   = (n_rs >= {1'b0, r_ctl[j].ud});
        assign n_diff = n_rs - {1'b0, r_ctl[j].ud};
        always_ff @(posedge i_clk) begin
            r_dvd[j+1] <= {r_dvd[j][NB-2:0], 1'b0};
            r_rem[j+1] <= n_ge ? n_diff[DW-1:0] : n_rs[DW-1:0];
            r_q[j+1]   <= {r_q[j][DW-2:0], n_ge};
            r_big[j+1] <= r_big[j] | r_q[j][DW-1];
            r_ctl[j+1] <= r_ctl[j];
        end
    end

    always_comb begin
        n_lim = (DW+1)'(cpd_pkg::MAX_FX) + (DW+1)'(r_ctl[NB].neg);
        if (r_ctl[NB].dz) begin
            n_quot.ovf = 1'b1;
            n_quot.val = r_ctl[NB].npos ? cpd_pkg::MAX_FX
                       : (r_ctl[NB].nneg ? cpd_pkg::MIN_FX : '0);
        end else if (r_big[NB] || ({1'b0, r_q[NB]} > n_lim)) begin
            n_quot.ovf = 1'b1;
            n_quot.val = r_ctl[NB].neg ? cpd_pkg::MIN_FX : cpd_pkg::MAX_FX;
        end else begin
            n_quot.ovf = 1'b0;
            n_quot.val = r_ctl[NB].neg ? cpd_pkg::t_fx'(~r_q[NB] + DW'(1))
                                       : cpd_pkg::t_fx'(r_q[NB]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_quot <= n_quot;
        r_out_side <= r_ctl[NB].side;
    end

    assign o_valid = r_out_vld;
    assign o_quot  = r_out_quot;
    assign o_side  = r_out_side;

endmodule

// ===== rtl/cart_pendulum_derivatives.sv =====
`timescale 1ns / 1ps

// Cart-pendulum derivatives, fully pipelined: one request may be started in
// every clock cycle and busy never rises. Each request yields one result,
// marked by o_valid for one cycle; the depth is set mostly by the 30-step
// CORDIC with its angle reduction and the bit-per-stage divider. Results
// cannot be held back, so the receiver must take every strobe. Registers are
// written through the cfg channel, which is always ready; write them only
// when no request is in flight.

module cart_pendulum_derivatives (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  cpd_pkg::t_req   i_req,
    output logic            o_valid,
    output cpd_pkg::t_res   o_result,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  cpd_pkg::t_idx   i_cfg_index,
    input  cpd_pkg::t_reg   i_cfg_data
);

    localparam int PIPE_LATENCY = 112;

    cpd_pkg::t_reg  r_cfg [cpd_pkg::NUM_REGS];

    cpd_pkg::t_fx   cfg_g, cfg_b, cfg_ml, cfg_mm, cfg_minv, cfg_hml, cfg_l43;

    logic           c_vld;
    cpd_pkg::t_req  c_req;
    cpd_pkg::t_fx   c_sin, c_cos;

    logic [8:0]     r_fv;
    logic [3:0]     r_bv;

    // M1a
    cpd_pkg::t_fx   r_m1a_v, r_m1a_w, r_m1a_u, r_m1a_c;
    cpd_pkg::t_prod r_m1a_ww, r_m1a_bv, r_m1a_mls, r_m1a_gs, r_m1a_hw, r_m1a_mlc, r_m1a_mml;
    // M1b
    cpd_pkg::t_fx   r_m1b_v, r_m1b_w, r_m1b_u, r_m1b_c;
    cpd_pkg::t_fx   r_m1b_ww, r_m1b_bv, r_m1b_mls, r_m1b_gs, r_m1b_hw, r_m1b_mlc, r_m1b_mml;
    logic           r_m1b_ovf;
    // A1
    cpd_pkg::t_fx   r_a1_t0, r_a1_grav, r_a1_ww, r_a1_mls, r_a1_mlc, r_a1_c, r_a1_mml;
    cpd_pkg::t_fx   r_a1_v, r_a1_w;
    logic           r_a1_ovf;
    // M2a
    cpd_pkg::t_prod r_m2a_mw, r_m2a_mg, r_m2a_dc;
    cpd_pkg::t_fx   r_m2a_t0, r_m2a_mml, r_m2a_mlc, r_m2a_c, r_m2a_v, r_m2a_w;
    logic           r_m2a_ovf;
    // M2b
    cpd_pkg::t_fx   r_m2b_mw, r_m2b_mg, r_m2b_dc;
    cpd_pkg::t_fx   r_m2b_t0, r_m2b_mml, r_m2b_mlc, r_m2b_c, r_m2b_v, r_m2b_w;
    logic           r_m2b_ovf;
    // A2
    cpd_pkg::t_fx   r_a2_t1, r_a2_den, r_a2_mg, r_a2_mlc, r_a2_c, r_a2_v, r_a2_w;
    logic           r_a2_ovf;
    // M3a
    cpd_pkg::t_prod r_m3a_ct;
    cpd_pkg::t_fx   r_m3a_mg, r_m3a_den, r_m3a_t1, r_m3a_mlc, r_m3a_v, r_m3a_w;
    logic           r_m3a_ovf;
    // M3b
    cpd_pkg::t_fx   r_m3b_ct, r_m3b_mg, r_m3b_den, r_m3b_t1, r_m3b_mlc, r_m3b_v, r_m3b_w;
    logic           r_m3b_ovf;
    // A3
    cpd_pkg::t_fx   r_a3_num, r_a3_den;
    cpd_pkg::t_side r_a3_side;

    logic           d_vld;
    cpd_pkg::t_sat  d_quot;
    cpd_pkg::t_side d_side;

    // M4a, M4b, A4, M5a, out
    cpd_pkg::t_prod r_m4a_ma;
    cpd_pkg::t_fx   r_m4a_acc;
    cpd_pkg::t_side r_m4a_side;
    cpd_pkg::t_fx   r_m4b_ma, r_m4b_acc;
    cpd_pkg::t_side r_m4b_side;
    cpd_pkg::t_fx   r_a4_x, r_a4_acc;
    cpd_pkg::t_side r_a4_side;
    cpd_pkg::t_prod r_m5a_vr;
    cpd_pkg::t_fx   r_m5a_acc;
    cpd_pkg::t_side r_m5a_side;
    logic           r_out_vld;
    cpd_pkg::t_res  r_out;

    cpd_pkg::t_sat  n_ww, n_bv, n_mls, n_gs, n_hw, n_mlc, n_mml;
    cpd_pkg::t_sat  n_t0, n_grav, n_mw, n_mg, n_dc, n_t1, n_den, n_ct, n_num;
    cpd_pkg::t_sat  n_ma, n_x, n_vr;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cpd_pkg::NUM_REGS; k++) begin
                r_cfg[k] <= cpd_pkg::REG_RESET[k];
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cpd_pkg::REG_GRAVITY:     r_cfg[cpd_pkg::REG_GRAVITY]     <= i_cfg_data;
                cpd_pkg::REG_CART_FRIC:   r_cfg[cpd_pkg::REG_CART_FRIC]   <= i_cfg_data;
                cpd_pkg::REG_MASS_LEN:    r_cfg[cpd_pkg::REG_MASS_LEN]    <= i_cfg_data;
                cpd_pkg::REG_TOTAL_MASS:  r_cfg[cpd_pkg::REG_TOTAL_MASS]  <= i_cfg_data;
                cpd_pkg::REG_INV_MASS:    r_cfg[cpd_pkg::REG_INV_MASS]    <= i_cfg_data;
                cpd_pkg::REG_DAMP_ML:     r_cfg[cpd_pkg::REG_DAMP_ML]     <= i_cfg_data;
                cpd_pkg::REG_FOUR_THIRDS: r_cfg[cpd_pkg::REG_FOUR_THIRDS] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg_g    = {1'b0, r_cfg[cpd_pkg::REG_GRAVITY]};
    assign cfg_b    = {1'b0, r_cfg[cpd_pkg::REG_CART_FRIC]};
    assign cfg_ml   = {1'b0, r_cfg[cpd_pkg::REG_MASS_LEN]};
    assign cfg_mm   = {1'b0, r_cfg[cpd_pkg::REG_TOTAL_MASS]};
    assign cfg_minv = {1'b0, r_cfg[cpd_pkg::REG_INV_MASS]};
    assign cfg_hml  = {1'b0, r_cfg[cpd_pkg::REG_DAMP_ML]};
    assign cfg_l43  = {1'b0, r_cfg[cpd_pkg::REG_FOUR_THIRDS]};

    cpd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_req   (i_req),
        .o_valid (c_vld),
        .o_req   (c_req),
        .o_sin   (c_sin),
        .o_cos   (c_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv      <= '0;
            r_bv      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_fv      <= {r_fv[7:0], c_vld};
            r_bv      <= {r_bv[2:0], d_vld};
            r_out_vld <= r_bv[3];
        end
    end

    always_comb begin
        n_ww   = cpd_pkg::mul_round(r_m1a_ww);
        n_bv   = cpd_pkg::mul_round(r_m1a_bv);
        n_mls  = cpd_pkg::mul_round(r_m1a_mls);
        n_gs   = cpd_pkg::mul_round(r_m1a_gs);
        n_hw   = cpd_pkg::mul_round(r_m1a_hw);
        n_mlc  = cpd_pkg::mul_round(r_m1a_mlc);
        n_mml  = cpd_pkg::mul_round(r_m1a_mml);
        n_t0   = cpd_pkg::add_sat(r_m1b_u, r_m1b_bv, 1'b1);
        n_grav = cpd_pkg::add_sat(r_m1b_gs, r_m1b_hw, 1'b1);
        n_mw   = cpd_pkg::mul_round(r_m2a_mw);
        n_mg   = cpd_pkg::mul_round(r_m2a_mg);
        n_dc   = cpd_pkg::mul_round(r_m2a_dc);
        n_t1   = cpd_pkg::add_sat(r_m2b_t0, r_m2b_mw, 1'b0);
        n_den  = cpd_pkg::add_sat(r_m2b_dc, r_m2b_mml, 1'b1);
        n_ct   = cpd_pkg::mul_round(r_m3a_ct);
        n_num  = cpd_pkg::add_sat(r_m3b_ct, r_m3b_mg, 1'b1);
        n_ma   = cpd_pkg::mul_round(r_m4a_ma);
        n_x    = cpd_pkg::add_sat(r_m4b_side.t1, r_m4b_ma, 1'b1);
        n_vr   = cpd_pkg::mul_round(r_m5a_vr);
    end

    always_ff @(posedge i_clk) begin
        r_m1a_v   <= c_req.cart_velocity;
        r_m1a_w   <= c_req.pole_rate;
        r_m1a_u   <= c_req.force_req;
        r_m1a_c   <= c_cos;
        r_m1a_ww  <= cpd_pkg::mul_raw(c_req.pole_rate, c_req.pole_rate);
        r_m1a_bv  <= cpd_pkg::mul_raw(cfg_b, c_req.cart_velocity);
        r_m1a_mls <= cpd_pkg::mul_raw(cfg_ml, c_sin);
        r_m1a_gs  <= cpd_pkg::mul_raw(cfg_g, c_sin);
        r_m1a_hw  <= cpd_pkg::mul_raw(cfg_hml, c_req.pole_rate);
        r_m1a_mlc <= cpd_pkg::mul_raw(cfg_ml, c_cos);
        r_m1a_mml <= cpd_pkg::mul_raw(cfg_mm, cfg_l43);

        r_m1b_v   <= r_m1a_v;
        r_m1b_w   <= r_m1a_w;
        r_m1b_u   <= r_m1a_u;
        r_m1b_c   <= r_m1a_c;
        r_m1b_ww  <= n_ww.val;
        r_m1b_bv  <= n_bv.val;
        r_m1b_mls <= n_mls.val;
        r_m1b_gs  <= n_gs.val;
        r_m1b_hw  <= n_hw.val;
        r_m1b_mlc <= n_mlc.val;
        r_m1b_mml <= n_mml.val;
        r_m1b_ovf <= n_ww.ovf | n_bv.ovf | n_mls.ovf | n_gs.ovf | n_hw.ovf
                     | n_mlc.ovf | n_mml.ovf;

        r_a1_t0   <= n_t0.val;
        r_a1_grav <= n_grav.val;
        r_a1_ww   <= r_m1b_ww;
        r_a1_mls  <= r_m1b_mls;
        r_a1_mlc  <= r_m1b_mlc;
        r_a1_c    <= r_m1b_c;
        r_a1_mml  <= r_m1b_mml;
        r_a1_v    <= r_m1b_v;
        r_a1_w    <= r_m1b_w;
        r_a1_ovf  <= r_m1b_ovf | n_t0.ovf | n_grav.ovf;

        r_m2a_mw  <= cpd_pkg::mul_raw(r_a1_mls, r_a1_ww);
        r_m2a_mg  <= cpd_pkg::mul_raw(cfg_mm, r_a1_grav);
        r_m2a_dc  <= cpd_pkg::mul_raw(r_a1_mlc, r_a1_c);
        r_m2a_t0  <= r_a1_t0;
        r_m2a_mml <= r_a1_mml;
        r_m2a_mlc <= r_a1_mlc;
        r_m2a_c   <= r_a1_c;
        r_m2a_v   <= r_a1_v;
        r_m2a_w   <= r_a1_w;
        r_m2a_ovf <= r_a1_ovf;

        r_m2b_mw  <= n_mw.val;
        r_m2b_mg  <= n_mg.val;
        r_m2b_dc  <= n_dc.val;
        r_m2b_t0  <= r_m2a_t0;
        r_m2b_mml <= r_m2a_mml;
        r_m2b_mlc <= r_m2a_mlc;
        r_m2b_c   <= r_m2a_c;
        r_m2b_v   <= r_m2a_v;
        r_m2b_w   <= r_m2a_w;
        r_m2b_ovf <= r_m2a_ovf | n_mw.ovf | n_mg.ovf | n_dc.ovf;

        r_a2_t1   <= n_t1.val;
        r_a2_den  <= n_den.val;
        r_a2_mg   <= r_m2b_mg;
        r_a2_mlc  <= r_m2b_mlc;
        r_a2_c    <= r_m2b_c;
        r_a2_v    <= r_m2b_v;
        r_a2_w    <= r_m2b_w;
        r_a2_ovf  <= r_m2b_ovf | n_t1.ovf | n_den.ovf;

        r_m3a_ct  <= cpd_pkg::mul_raw(r_a2_c, r_a2_t1);
        r_m3a_mg  <= r_a2_mg;
        r_m3a_den <= r_a2_den;
        r_m3a_t1  <= r_a2_t1;
        r_m3a_mlc <= r_a2_mlc;
        r_m3a_v   <= r_a2_v;
        r_m3a_w   <= r_a2_w;
        r_m3a_ovf <= r_a2_ovf;

        r_m3b_ct  <= n_ct.val;
        r_m3b_mg  <= r_m3a_mg;
        r_m3b_den <= r_m3a_den;
        r_m3b_t1  <= r_m3a_t1;
        r_m3b_mlc <= r_m3a_mlc;
        r_m3b_v   <= r_m3a_v;
        r_m3b_w   <= r_m3a_w;
        r_m3b_ovf <= r_m3a_ovf | n_ct.ovf;

        r_a3_num       <= n_num.val;
        r_a3_den       <= r_m3b_den;
        r_a3_side.v    <= r_m3b_v;
        r_a3_side.w    <= r_m3b_w;
        r_a3_side.t1   <= r_m3b_t1;
        r_a3_side.mlc  <= r_m3b_mlc;
        r_a3_side.ovf  <= r_m3b_ovf | n_num.ovf;
    end

    cpd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fv[8]),
        .i_num   (r_a3_num),
        .i_den   (r_a3_den),
        .i_side  (r_a3_side),
        .o_valid (d_vld),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    always_ff @(posedge i_clk) begin
        r_m4a_ma       <= cpd_pkg::mul_raw(d_side.mlc, d_quot.val);
        r_m4a_acc      <= d_quot.val;
        r_m4a_side     <= {d_side.v, d_side.w, d_side.t1, d_side.mlc,
                           d_side.ovf | d_quot.ovf};

        r_m4b_ma       <= n_ma.val;
        r_m4b_acc      <= r_m4a_acc;
        r_m4b_side     <= {r_m4a_side.v, r_m4a_side.w, r_m4a_side.t1, r_m4a_side.mlc,
                           r_m4a_side.ovf | n_ma.ovf};

        r_a4_x         <= n_x.val;
        r_a4_acc       <= r_m4b_acc;
        r_a4_side      <= {r_m4b_side.v, r_m4b_side.w, r_m4b_side.t1, r_m4b_side.mlc,
                           r_m4b_side.ovf | n_x.ovf};

        r_m5a_vr       <= cpd_pkg::mul_raw(cfg_minv, r_a4_x);
        r_m5a_acc      <= r_a4_acc;
        r_m5a_side     <= r_a4_side;

        r_out.position_rate <= r_m5a_side.v;
        r_out.velocity_rate <= n_vr.val;
        r_out.angle_rate    <= r_m5a_side.w;
        r_out.angular_accel <= r_m5a_acc;
        r_out.saturated     <= r_m5a_side.ovf | n_vr.ovf;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_strobe_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LATENCY o_valid)
        else $error("result strobe missing for a request");

    a_no_spurious_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result strobe without a request");

    a_velocity_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.position_rate == $past(i_req.cart_velocity, PIPE_LATENCY)))
        else $error("position rate does not match request velocity");

    a_rate_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.angle_rate == $past(i_req.pole_rate, PIPE_LATENCY)))
        else $error("angle rate does not match request pole rate");
`endif

endmodule

// ===== bench/cart_pendulum_derivatives_tb.sv =====
`timescale 1ns / 1ps

module cart_pendulum_derivatives_tb;
    import cpd_pkg::*;

    localparam int   PIPE_LATENCY = 112;
    localparam t_idx UNUSED_INDEX = 3'd7;
    localparam t_idx REG_ORDER [NUM_REGS] = '{
        REG_GRAVITY, REG_CART_FRIC, REG_MASS_LEN, REG_TOTAL_MASS,
        REG_INV_MASS, REG_DAMP_ML, REG_FOUR_THIRDS
    };
    localparam t_fx HALF_PI_FX = 32'sd1647099;
    localparam t_fx PI_FX      = 32'sd3294199;
    localparam t_fx ONE_FX     = 32'sd1048576;

    typedef enum int {
        REGS_RESET, REGS_NO_INERTIA, REGS_PLAUSIBLE, REGS_ALL_MAX, REGS_ALL_ZERO, REGS_ANY
    } t_reg_mode;

    class derivative_scoreboard;
        longint coef [NUM_REGS];
        bit     clipped;
        t_res   expected_q[$];
        int     fails;
        longint atan_tab [10] = '{
            843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149
        };

        function new();
            foreach (coef[i]) coef[i] = longint'(REG_RESET[i]);
            fails = 0;
        endfunction

        function void write_reg(t_idx idx, t_reg data);
            if (idx < NUM_REGS) coef[idx] = longint'(data);
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647) begin
                clipped = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                clipped = 1'b1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint mul_q(longint a, longint b);
            longint p;
            longint m;
            p = a * b;
            m = p < 0 ? -p : p;
            m = (m + 64'sd524288) >>> 20;
            return clip(p < 0 ? -m : m);
        endfunction

        function longint div_q(longint n, longint d);
            longint q;
            longint dm;
            if (d == 0) begin
                clipped = 1'b1;
                return n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 64'sd0);
            end
            dm = d < 0 ? -d : d;
            q = ((n < 0 ? -n : n) <<< 20) / dm;
            return clip(((n < 0) != (d < 0)) ? -q : q);
        endfunction

        function longint q30_round(longint v);
            longint m;
            m = ((v < 0 ? -v : v) + 64'sd512) >>> 10;
            return clip(v < 0 ? -m : m);
        endfunction

        function void sine_cosine(longint ang, output longint s, output longint c);
            longint turn;
            longint r;
            longint z;
            longint x;
            longint y;
            longint xs;
            longint ys;
            longint a;
            bit     flip;
            turn = longint'((64'h6487ED5110B4611A + (64'd1 << 39)) >> 40);
            r = ang % turn;
            if (r < 0) r += turn;
            z = r <<< 10;
            if (z > 64'sd3373259426) z -= 64'sd6746518852;
            flip = 1'b0;
            if (z > 64'sd1686629713) begin
                z -= 64'sd3373259426;
                flip = 1'b1;
            end else if (z < -64'sd1686629713) begin
                z += 64'sd3373259426;
                flip = 1'b1;
            end
            x = 64'sd652032874;
            y = 0;
            for (int i = 0; i < 30; i++) begin
                a  = i < 10 ? atan_tab[i] : (64'sd1 <<< (30 - i));
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys;
                    y += xs;
                    z -= a;
                end else begin
                    x += ys;
                    y -= xs;
                    z += a;
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            s = q30_round(y);
            c = q30_round(x);
        endfunction

        function void note(t_req r);
            longint v, th, w, u, s, c, w2, t1, grav, num, mlc, den, acc, vr;
            t_res   e;
            clipped = 1'b0;
            v  = longint'(r.cart_velocity);
            th = longint'(r.pole_angle);
            w  = longint'(r.pole_rate);
            u  = longint'(r.force_req);
            sine_cosine(th, s, c);
            w2   = mul_q(w, w);
            t1   = clip(clip(u - mul_q(coef[REG_CART_FRIC], v))
                        + mul_q(mul_q(coef[REG_MASS_LEN], s), w2));
            grav = clip(mul_q(coef[REG_GRAVITY], s) - mul_q(coef[REG_DAMP_ML], w));
            num  = clip(mul_q(c, t1) - mul_q(coef[REG_TOTAL_MASS], grav));
            mlc  = mul_q(coef[REG_MASS_LEN], c);
            den  = clip(mul_q(mlc, c) - mul_q(coef[REG_TOTAL_MASS], coef[REG_FOUR_THIRDS]));
            acc  = div_q(num, den);
            vr   = mul_q(coef[REG_INV_MASS], clip(t1 - mul_q(mlc, acc)));
            e.position_rate = t_fx'(v);
            e.velocity_rate = t_fx'(vr);
            e.angle_rate    = t_fx'(w);
            e.angular_accel = t_fx'(acc);
            e.saturated     = clipped;
            expected_q.push_back(e);
        endfunction

        function void check(t_res got);
            t_res e;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                fails++;
                return;
            end
            e = expected_q.pop_front();
            if (got.position_rate !== e.position_rate) begin
                $error("position_rate: expected %0d, got %0d", e.position_rate, got.position_rate);
                fails++;
            end
            if (got.velocity_rate !== e.velocity_rate) begin
                $error("velocity_rate: expected %0d, got %0d", e.velocity_rate, got.velocity_rate);
                fails++;
            end
            if (got.angle_rate !== e.angle_rate) begin
                $error("angle_rate: expected %0d, got %0d", e.angle_rate, got.angle_rate);
                fails++;
            end
            if (got.angular_accel !== e.angular_accel) begin
                $error("angular_accel: expected %0d, got %0d", e.angular_accel, got.angular_accel);
                fails++;
            end
            if (got.saturated !== e.saturated) begin
                $error("saturated: expected %0b, got %0b", e.saturated, got.saturated);
                fails++;
            end
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_valid;
    t_res  o_result;
    logic  i_cfg_valid;
    logic  o_cfg_ready;
    t_idx  i_cfg_index;
    t_reg  i_cfg_data;

    derivative_scoreboard sb = new();

    cart_pendulum_derivatives i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check(o_result);
    end

    function automatic t_req make_req(t_fx v, t_fx th, t_fx w, t_fx u);
        t_req r;
        r.cart_velocity = v;
        r.pole_angle    = th;
        r.pole_rate     = w;
        r.force_req     = u;
        return r;
    endfunction

    function automatic t_fx rand_field(int span_bits);
        case ($urandom_range(0, 7))
            0, 1:    return t_fx'($urandom);
            2:       return t_fx'($signed($urandom_range(0, 64)) - 32);
            default: return t_fx'($signed($urandom_range(0, 2 ** span_bits)) - 2 ** (span_bits - 1));
        endcase
    endfunction

    task automatic send_request(t_req r, bit gaps);
        int n;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.note(r);
        if (gaps && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_idx idx, t_reg data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic load_regs(t_reg_mode mode);
        t_reg val;
        foreach (REG_ORDER[i]) begin
            case (mode)
                REGS_RESET:     val = REG_RESET[i];
                REGS_ALL_MAX:   val = {REG_W{1'b1}};
                REGS_ALL_ZERO:  val = '0;
                REGS_PLAUSIBLE: val = t_reg'($urandom_range(0, 2 ** 26));
                REGS_ANY:       val = t_reg'($urandom);
                default:        val = (REG_ORDER[i] == REG_MASS_LEN ||
                                       REG_ORDER[i] == REG_TOTAL_MASS) ? '0 : REG_RESET[i];
            endcase
            write_reg(REG_ORDER[i], val);
        end
        if (mode == REGS_ALL_ZERO) write_reg(UNUSED_INDEX, {REG_W{1'b1}});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(int count, bit gaps);
        for (int k = 0; k < count; k++)
            send_request(make_req(rand_field(23), rand_field(24), rand_field(23),
                                  rand_field(26)), gaps);
        drain();
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_GRAVITY;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(make_req(0, 0, 0, 0), 1);
        send_request(make_req(MAX_FX, MAX_FX, MAX_FX, MAX_FX), 1);
        send_request(make_req(MIN_FX, MIN_FX, MIN_FX, MIN_FX), 1);
        send_request(make_req(ONE_FX, HALF_PI_FX, ONE_FX, ONE_FX), 1);
        send_request(make_req(-ONE_FX, -HALF_PI_FX, -ONE_FX, ONE_FX), 0);
        send_request(make_req(0, PI_FX, ONE_FX, 0), 0);
        send_request(make_req(0, -PI_FX, -ONE_FX, 0), 1);
        send_request(make_req(0, 2 * PI_FX + 1, 0, ONE_FX), 0);
        send_request(make_req(0, MAX_FX, 0, MIN_FX), 0);
        send_request(make_req(MAX_FX, 0, 0, 0), 1);
        send_request(make_req(0, 0, MAX_FX, 0), 0);
        send_request(make_req(0, 0, MIN_FX, MAX_FX), 0);
        send_request(make_req(MIN_FX, HALF_PI_FX, 0, MIN_FX), 1);
        send_request(make_req(ONE_FX, 32'sd500000, 32'sd3000000, 32'sd2000000), 0);
        drain();

        load_regs(REGS_NO_INERTIA);
        send_request(make_req(0, 0, 0, ONE_FX), 0);
        send_request(make_req(0, 0, 0, -ONE_FX), 1);
        send_request(make_req(0, 0, 0, 0), 0);
        send_request(make_req(ONE_FX, PI_FX, ONE_FX, -ONE_FX), 0);
        drain();

        load_regs(REGS_RESET);
        run_random(200, 1);
        run_random(150, 1);
        load_regs(REGS_PLAUSIBLE);
        run_random(250, 1);
        load_regs(REGS_ALL_MAX);
        run_random(80, 1);
        load_regs(REGS_ALL_ZERO);
        run_random(60, 1);
        load_regs(REGS_ANY);
        run_random(120, 1);
        load_regs(REGS_RESET);
        run_random(220, 0);

        if (sb.fails == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cpd_pkg.sv
rtl/cpd_cordic.sv
rtl/cpd_divider.sv
rtl/cart_pendulum_derivatives.sv
bench/cart_pendulum_derivatives_tb.sv
